@@ rtl/motor_adc_frame_conditioner_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the motor ADC frame conditioner
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MOTOR_ADC_FRAME_CONDITIONER_ASSERT_SVH
`define MOTOR_ADC_FRAME_CONDITIONER_ASSERT_SVH

// same-cycle implication
`define MAFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mafc assertion failed");

// next-cycle implication
`define MAFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mafc assertion failed");

`endif

@@ rtl/mafc_pkg.sv @@
// ----------------------------------------------------------------------------
// mafc_pkg
// Types and constants shared by the motor ADC frame conditioner.
// ----------------------------------------------------------------------------
package mafc_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int LIMIT_BITS    = 16;
  localparam int MID_BITS      = 10;
  localparam int GAIN_BITS     = 16;
  localparam int TPM_BITS      = 8;
  localparam int MPS_BITS      = 10;
  localparam int AVG_OUT_BITS  = 10;
  localparam int MA_BITS       = 16;
  localparam int BUS_MA_BITS   = 15;
  localparam int COUNT_BITS    = 16;
  localparam int NUM_PHASES    = 3;

  typedef logic [SAMPLE_BITS-1:0]  sample_t;
  typedef logic [LIMIT_BITS-1:0]   limit_t;
  typedef logic [MID_BITS-1:0]     mid_t;
  typedef logic [GAIN_BITS-1:0]    gain_t;
  typedef logic [TPM_BITS-1:0]     tpm_t;
  typedef logic [MPS_BITS-1:0]     mps_t;
  typedef logic [AVG_OUT_BITS-1:0] avg_out_t;
  typedef logic [COUNT_BITS-1:0]   count_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PHASE_HIGH = 3'd0,
    REG_PHASE_LOW  = 3'd1,
    REG_BUS_HIGH   = 3'd2,
    REG_MIDPOINT   = 3'd3,
    REG_PHASE_GAIN = 3'd4,
    REG_BUS_GAIN   = 3'd5,
    REG_TICKS_MS   = 3'd6,
    REG_MS_SLOW    = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    SLOT_VOLT = 3'b001,
    SLOT_KNOB = 3'b010,
    SLOT_BUS  = 3'b100
  } slot_e;

  localparam limit_t RST_PHASE_HIGH = 16'd65535;
  localparam limit_t RST_PHASE_LOW  = 16'd0;
  localparam limit_t RST_BUS_HIGH   = 16'd65535;
  localparam mid_t   RST_MIDPOINT   = 10'd512;
  localparam gain_t  RST_PHASE_GAIN = 16'd3234;
  localparam gain_t  RST_BUS_GAIN   = 16'd1650;
  localparam tpm_t   RST_TICKS_MS   = 8'd20;
  localparam mps_t   RST_MS_SLOW    = 10'd500;

  typedef struct packed {
    logic signed [MA_BITS-1:0] ma;
    logic                      oc;
  } lane_res_t;

  typedef struct packed {
    count_t frame_count;
    count_t ms_count;
    logic   ms_pulse;
    logic   slow_pulse;
  } tb_status_t;

  typedef struct packed {
    avg_out_t                  bus_voltage_avg;
    avg_out_t                  knob_avg;
    logic signed [MA_BITS-1:0] phase_a_ma;
    logic signed [MA_BITS-1:0] phase_b_ma;
    logic signed [MA_BITS-1:0] phase_c_ma;
    logic [BUS_MA_BITS-1:0]    bus_ma;
    logic                      phase_overcurrent;
    logic                      bus_overcurrent;
    tb_status_t                tb;
  } out_word_t;

endpackage

@@ rtl/mafc_in_if.sv @@
// ----------------------------------------------------------------------------
// mafc_in_if
// Valid/ready channel carrying one ADC frame word.
// ----------------------------------------------------------------------------
interface mafc_in_if;
  import mafc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t mux_sample;
  sample_t phase_a_sample;
  sample_t phase_b_sample;
  sample_t phase_c_sample;

  modport source (
    output valid, mux_sample, phase_a_sample, phase_b_sample, phase_c_sample,
    input  ready
  );

  modport sink (
    input  valid, mux_sample, phase_a_sample, phase_b_sample, phase_c_sample,
    output ready
  );
endinterface

@@ rtl/mafc_out_if.sv @@
// ----------------------------------------------------------------------------
// mafc_out_if
// Valid/ready channel carrying one conditioned result word.
// ----------------------------------------------------------------------------
interface mafc_out_if;
  import mafc_pkg::*;

  logic                      valid;
  logic                      ready;
  avg_out_t                  bus_voltage_avg;
  avg_out_t                  knob_avg;
  logic signed [MA_BITS-1:0] phase_a_ma;
  logic signed [MA_BITS-1:0] phase_b_ma;
  logic signed [MA_BITS-1:0] phase_c_ma;
  logic [BUS_MA_BITS-1:0]    bus_ma;
  logic                      phase_overcurrent;
  logic                      bus_overcurrent;
  count_t                    frame_count;
  count_t                    ms_count;
  logic                      ms_pulse;
  logic                      slow_pulse;

  modport source (
    output valid, bus_voltage_avg, knob_avg, phase_a_ma, phase_b_ma, phase_c_ma,
           bus_ma, phase_overcurrent, bus_overcurrent, frame_count, ms_count,
           ms_pulse, slow_pulse,
    input  ready
  );

  modport sink (
    input  valid, bus_voltage_avg, knob_avg, phase_a_ma, phase_b_ma, phase_c_ma,
           bus_ma, phase_overcurrent, bus_overcurrent, frame_count, ms_count,
           ms_pulse, slow_pulse,
    output ready
  );
endinterface

@@ rtl/mafc_phase_lane.sv @@
// ----------------------------------------------------------------------------
// mafc_phase_lane
// One phase: signed mA around the midpoint, saturated, plus limit check.
// ----------------------------------------------------------------------------
module mafc_phase_lane #(
  parameter int CURRENT_SHIFT = 9
) (
  input  mafc_pkg::sample_t   raw_i,
  input  mafc_pkg::mid_t      mid_i,
  input  mafc_pkg::gain_t     gain_i,
  input  mafc_pkg::limit_t    high_i,
  input  mafc_pkg::limit_t    low_i,
  output mafc_pkg::lane_res_t res_o
);
  import mafc_pkg::*;

  localparam int PW = SAMPLE_BITS + GAIN_BITS;
  localparam logic [PW-1:0] POS_MAX = PW'((1 << (MA_BITS - 1)) - 1);
  localparam logic [PW-1:0] NEG_MAX = PW'(1 << (MA_BITS - 1));

  logic                neg;
  logic [MID_BITS-1:0] mag;
  logic [PW-1:0]       prod;
  logic [PW-1:0]       scaled;
  limit_t              raw_ext;

  assign neg     = raw_i < mid_i;
  assign mag     = neg ? MID_BITS'(mid_i - raw_i) : MID_BITS'(raw_i - mid_i);
  assign prod    = PW'(mag) * PW'(gain_i);
  assign scaled  = prod >> CURRENT_SHIFT;
  assign raw_ext = LIMIT_BITS'(raw_i);

  always_comb begin
    if (neg) begin
      if (scaled > NEG_MAX) begin
        res_o.ma = MA_BITS'(NEG_MAX);
      end else begin
        res_o.ma = MA_BITS'(MA_BITS'(0) - scaled[MA_BITS-1:0]);
      end
    end else begin
      if (scaled > POS_MAX) begin
        res_o.ma = MA_BITS'(POS_MAX);
      end else begin
        res_o.ma = scaled[MA_BITS-1:0];
      end
    end
    res_o.oc = (raw_ext > high_i) || (raw_ext < low_i);
  end

endmodule

@@ rtl/mafc_batch_avg.sv @@
// ----------------------------------------------------------------------------
// mafc_batch_avg
// Batch averager: first sample passes, then one result per 2^LOG2N samples.
// ----------------------------------------------------------------------------
module mafc_batch_avg #(
  parameter int LOG2N = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  mafc_pkg::sample_t sample_i,
  output mafc_pkg::sample_t avg_o
);
  import mafc_pkg::*;

  localparam int SW = SAMPLE_BITS + LOG2N;

  logic [SW-1:0]    sum_q, sum_d, sum_add;
  logic [LOG2N-1:0] cnt_q, cnt_d;
  logic             primed_q, primed_d;
  sample_t          avg_q, avg_d;

  assign sum_add = sum_q + SW'(sample_i);

  always_comb begin
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    primed_d = primed_q;
    avg_d    = avg_q;
    if (en_i) begin
      if (primed_q) begin
        if (cnt_q == '1) begin
          avg_d = sum_add[SW-1:LOG2N];
          sum_d = '0;
          cnt_d = '0;
        end else begin
          sum_d = sum_add;
          cnt_d = LOG2N'(cnt_q + 1'b1);
        end
      end else begin
        avg_d    = sample_i;
        primed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      cnt_q    <= '0;
      primed_q <= 1'b0;
      avg_q    <= '0;
    end else begin
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      primed_q <= primed_d;
      avg_q    <= avg_d;
    end
  end

  assign avg_o = avg_d;

endmodule

@@ rtl/mafc_timebase.sv @@
// ----------------------------------------------------------------------------
// mafc_timebase
// Frame counter with millisecond and slow tick dividers.
// ----------------------------------------------------------------------------
module mafc_timebase (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  mafc_pkg::tpm_t       ticks_per_ms_i,
  input  mafc_pkg::mps_t       ms_per_slow_i,
  output mafc_pkg::tb_status_t st_o
);
  import mafc_pkg::*;

  tpm_t              frames_q, frames_d;
  mps_t              slow_q, slow_d;
  count_t            frame_ticks_q, frame_ticks_d;
  count_t            ms_ticks_q, ms_ticks_d;
  logic [TPM_BITS:0] frames_inc;
  logic [MPS_BITS:0] slow_inc;
  logic              ms_fire, slow_fire;

  assign frames_inc = (TPM_BITS + 1)'(frames_q) + 1'b1;
  assign slow_inc   = (MPS_BITS + 1)'(slow_q) + 1'b1;
  assign ms_fire    = frames_inc >= (TPM_BITS + 1)'(ticks_per_ms_i);
  assign slow_fire  = ms_fire && (slow_inc >= (MPS_BITS + 1)'(ms_per_slow_i));

  always_comb begin
    frame_ticks_d = COUNT_BITS'(frame_ticks_q + 1'b1);
    frames_d      = ms_fire ? '0 : frames_inc[TPM_BITS-1:0];
    ms_ticks_d    = ms_fire ? COUNT_BITS'(ms_ticks_q + 1'b1) : ms_ticks_q;
    if (!ms_fire) begin
      slow_d = slow_q;
    end else if (slow_fire) begin
      slow_d = '0;
    end else begin
      slow_d = slow_inc[MPS_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q      <= '0;
      slow_q        <= '0;
      frame_ticks_q <= '0;
      ms_ticks_q    <= '0;
    end else if (en_i) begin
      frames_q      <= frames_d;
      slow_q        <= slow_d;
      frame_ticks_q <= frame_ticks_d;
      ms_ticks_q    <= ms_ticks_d;
    end
  end

  assign st_o.frame_count = frame_ticks_d;
  assign st_o.ms_count    = ms_ticks_d;
  assign st_o.ms_pulse    = ms_fire;
  assign st_o.slow_pulse  = slow_fire;

endmodule

@@ rtl/motor_adc_frame_conditioner.sv @@
// ----------------------------------------------------------------------------
// motor_adc_frame_conditioner
// Per-frame ADC conditioning: averages, mA scaling, overcurrent, time base.
// ----------------------------------------------------------------------------
// Takes one ADC frame word per clock while ready is high and returns one
// result word per frame from a two-word output buffer. The three phase
// currents are handled by parallel lanes (one 10x16 multiply each) whose
// results merge with the batch averagers, the bus current scaler and the
// time base into the output register. Input ready drops only while both
// buffer words are occupied, so with the output side taking every word the
// block sustains one frame per cycle. Configuration writes take effect on
// the next frame.
module motor_adc_frame_conditioner #(
  parameter int VOLTAGE_BATCH_LOG2 = 6,
  parameter int KNOB_BATCH_LOG2    = 3,
  parameter int CURRENT_SHIFT      = 9
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  mafc_in_if.sink                              in_i,
  mafc_out_if.source                           out_o,
  input  logic                                 cfg_we_i,
  input  logic [mafc_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [mafc_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import mafc_pkg::*;

  localparam int BW = SAMPLE_BITS + GAIN_BITS;
  localparam logic [BW-1:0] BUS_MAX = BW'((1 << BUS_MA_BITS) - 1);

  limit_t phase_high_q, phase_low_q, bus_high_q;
  mid_t   midpoint_q;
  gain_t  phase_gain_q, bus_gain_q;
  tpm_t   ticks_ms_q;
  mps_t   ms_slow_q;

  slot_e   slot_q, slot_d;
  sample_t bus_raw_q, bus_raw_d;
  logic    accept, volt_en, knob_en;

  sample_t    volt_avg, knob_avg;
  tb_status_t tb_st;
  sample_t    phase_raw [NUM_PHASES];
  lane_res_t  lane_res  [NUM_PHASES];

  logic [BW-1:0] bus_prod, bus_scaled;
  out_word_t     word_d, main_q, skid_q;
  logic          out_valid_q, skid_valid_q, pop;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_high_q <= RST_PHASE_HIGH;
      phase_low_q  <= RST_PHASE_LOW;
      bus_high_q   <= RST_BUS_HIGH;
      midpoint_q   <= RST_MIDPOINT;
      phase_gain_q <= RST_PHASE_GAIN;
      bus_gain_q   <= RST_BUS_GAIN;
      ticks_ms_q   <= RST_TICKS_MS;
      ms_slow_q    <= RST_MS_SLOW;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_PHASE_HIGH: phase_high_q <= cfg_data_i[LIMIT_BITS-1:0];
        REG_PHASE_LOW:  phase_low_q  <= cfg_data_i[LIMIT_BITS-1:0];
        REG_BUS_HIGH:   bus_high_q   <= cfg_data_i[LIMIT_BITS-1:0];
        REG_MIDPOINT:   midpoint_q   <= cfg_data_i[MID_BITS-1:0];
        REG_PHASE_GAIN: phase_gain_q <= cfg_data_i[GAIN_BITS-1:0];
        REG_BUS_GAIN:   bus_gain_q   <= cfg_data_i[GAIN_BITS-1:0];
        REG_TICKS_MS:   ticks_ms_q   <= cfg_data_i[TPM_BITS-1:0];
        REG_MS_SLOW:    ms_slow_q    <= cfg_data_i[MPS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign accept = in_i.valid && in_i.ready;

  // mux channel slot rotation
  always_comb begin
    volt_en   = 1'b0;
    knob_en   = 1'b0;
    bus_raw_d = bus_raw_q;
    case (slot_q)
      SLOT_VOLT: begin
        volt_en = accept;
        slot_d  = SLOT_KNOB;
      end
      SLOT_KNOB: begin
        knob_en = accept;
        slot_d  = SLOT_BUS;
      end
      SLOT_BUS: begin
        bus_raw_d = in_i.mux_sample;
        slot_d    = SLOT_VOLT;
      end
      default: begin
        slot_d = SLOT_VOLT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= SLOT_VOLT;
      bus_raw_q <= '0;
    end else if (accept) begin
      slot_q    <= slot_d;
      bus_raw_q <= bus_raw_d;
    end
  end

  mafc_batch_avg #(.LOG2N(VOLTAGE_BATCH_LOG2)) u_volt_avg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (volt_en),
    .sample_i (in_i.mux_sample),
    .avg_o    (volt_avg)
  );

  mafc_batch_avg #(.LOG2N(KNOB_BATCH_LOG2)) u_knob_avg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (knob_en),
    .sample_i (in_i.mux_sample),
    .avg_o    (knob_avg)
  );

  mafc_timebase u_timebase (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (accept),
    .ticks_per_ms_i (ticks_ms_q),
    .ms_per_slow_i  (ms_slow_q),
    .st_o           (tb_st)
  );

  assign phase_raw[0] = in_i.phase_a_sample;
  assign phase_raw[1] = in_i.phase_b_sample;
  assign phase_raw[2] = in_i.phase_c_sample;

  for (genvar g = 0; g < NUM_PHASES; g++) begin : g_lane
    mafc_phase_lane #(.CURRENT_SHIFT(CURRENT_SHIFT)) u_lane (
      .raw_i  (phase_raw[g]),
      .mid_i  (midpoint_q),
      .gain_i (phase_gain_q),
      .high_i (phase_high_q),
      .low_i  (phase_low_q),
      .res_o  (lane_res[g])
    );
  end

  // merge
  assign bus_prod   = BW'(bus_raw_d) * BW'(bus_gain_q);
  assign bus_scaled = bus_prod >> CURRENT_SHIFT;

  always_comb begin
    word_d.bus_voltage_avg   = AVG_OUT_BITS'(volt_avg);
    word_d.knob_avg          = AVG_OUT_BITS'(knob_avg);
    word_d.phase_a_ma        = lane_res[0].ma;
    word_d.phase_b_ma        = lane_res[1].ma;
    word_d.phase_c_ma        = lane_res[2].ma;
    word_d.bus_ma            = (bus_scaled > BUS_MAX) ? BUS_MA_BITS'(BUS_MAX)
                                                      : bus_scaled[BUS_MA_BITS-1:0];
    word_d.phase_overcurrent = lane_res[0].oc || lane_res[1].oc || lane_res[2].oc;
    word_d.bus_overcurrent   = LIMIT_BITS'(bus_raw_d) > bus_high_q;
    word_d.tb                = tb_st;
  end

  // two-word output buffer
  assign pop        = out_valid_q && out_o.ready;
  assign in_i.ready = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (accept) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      main_q <= skid_q;
    end else if (accept && (pop || !out_valid_q)) begin
      main_q <= word_d;
    end
    if (accept && out_valid_q && !pop) begin
      skid_q <= word_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.bus_voltage_avg   = main_q.bus_voltage_avg;
  assign out_o.knob_avg          = main_q.knob_avg;
  assign out_o.phase_a_ma        = main_q.phase_a_ma;
  assign out_o.phase_b_ma        = main_q.phase_b_ma;
  assign out_o.phase_c_ma        = main_q.phase_c_ma;
  assign out_o.bus_ma            = main_q.bus_ma;
  assign out_o.phase_overcurrent = main_q.phase_overcurrent;
  assign out_o.bus_overcurrent   = main_q.bus_overcurrent;
  assign out_o.frame_count       = main_q.tb.frame_count;
  assign out_o.ms_count          = main_q.tb.ms_count;
  assign out_o.ms_pulse          = main_q.tb.ms_pulse;
  assign out_o.slow_pulse        = main_q.tb.slow_pulse;

endmodule

@@ rtl/mafc_checker.sv @@
// ----------------------------------------------------------------------------
// mafc_checker
// Port-level checks on the result stream of the frame conditioner.
// ----------------------------------------------------------------------------
`include "motor_adc_frame_conditioner_assert.svh"

module mafc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [15:0]                frame_count_i,
  input logic [15:0]                ms_count_i,
  input logic                       ms_pulse_i,
  input logic                       slow_pulse_i
);
  import mafc_pkg::*;

  count_t prev_frame_q;
  count_t prev_ms_q;
  logic   take;

  assign take = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_frame_q <= '0;
      prev_ms_q    <= '0;
    end else if (take) begin
      prev_frame_q <= frame_count_i;
      prev_ms_q    <= ms_count_i;
    end
  end

  `MAFC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
                    out_valid_i && $stable(frame_count_i))
  `MAFC_ASSERT_NOW(a_frame_seq, take, frame_count_i == COUNT_BITS'(prev_frame_q + 1'b1))
  `MAFC_ASSERT_NOW(a_ms_seq, take, ms_count_i == COUNT_BITS'(prev_ms_q + ms_pulse_i))
  `MAFC_ASSERT_NOW(a_slow_in_ms, out_valid_i && slow_pulse_i, ms_pulse_i)

endmodule

bind motor_adc_frame_conditioner mafc_checker u_mafc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .frame_count_i (out_o.frame_count),
  .ms_count_i    (out_o.ms_count),
  .ms_pulse_i    (out_o.ms_pulse),
  .slow_pulse_i  (out_o.slow_pulse)
);
